### design/abts_pkg.sv
`timescale 1ns / 1ps

package abts_pkg;

   localparam int ADDR_W          = 32;
   localparam int LIST_W          = 16;
   localparam int REG_W           = 4;
   localparam int CYCLES_W        = 5;
   localparam int NUM_REGS_DEF    = 16;
   localparam int ADDR_SPACE_DEF  = 26;
   localparam logic [REG_W-1:0] PC_REG = 4'd15;

   typedef enum logic [2:0] {
      KIND_XFER     = 3'd0,
      KIND_WB       = 3'd1,
      KIND_DONE     = 3'd2,
      KIND_ADDR_EXC = 3'd3,
      KIND_ABORT    = 3'd4
   } kind_type;

   // instruction bits 24:23, bit 0 is the up/down bit
   typedef enum logic [1:0] {
      MODE_DA = 2'd0,
      MODE_IA = 2'd1,
      MODE_DB = 2'd2,
      MODE_IB = 2'd3
   } mode_type;

   typedef struct packed {
      logic              op;
      logic [LIST_W-1:0] reg_list;
      mode_type          addr_mode;
      logic              s_flag;
      logic              write_back;
      logic [REG_W-1:0]  base_reg;
      logic [ADDR_W-1:0] base_addr;
      logic              mem_fault;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   word_addr;
      logic [REG_W-1:0]    reg_num;
      logic                user_bank;
      logic                restore_psr;
      logic [ADDR_W-1:0]   wb_value;
      logic [CYCLES_W-1:0] cycles;
      logic                flush;
      logic                last;
   } rsp_type;

   // operand set for the shared address adder
   typedef struct packed {
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      logic              sub;
   } add_op_type;

endpackage

### design/abts_addr_unit.sv
`timescale 1ns / 1ps

// shared 32-bit add/subtract unit for start, end and step addresses
module abts_addr_unit (
   input  abts_pkg::add_op_type          op,
   output logic [abts_pkg::ADDR_W-1:0]   y
);

   always_comb begin
      if (op.sub) begin
         y = op.a - op.b;
      end else begin
         y = op.a + op.b;
      end
   end

endmodule

### design/arm_block_transfer_sequencer.sv
`timescale 1ns / 1ps

// Order: after a request is accepted, START and END form the addresses; CHECK strobes an
// exception or a load write-back item, XFER then strobes transfers one per cycle, POST a store
// write-back item and DONE the closing item. Busy stays high from the accept until the closing
// item or exception is strobed, and a new request is taken only once the sequencer is idle.
// Reset: synchronous, active high; returns to idle with the strobe low.
// Results are strobed for one cycle each; the receiver cannot stall them.
module arm_block_transfer_sequencer #(
   parameter int NUM_REGS        = abts_pkg::NUM_REGS_DEF,
   parameter int ADDR_SPACE_BITS = abts_pkg::ADDR_SPACE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  abts_pkg::req_type req_data,
   output logic              rsp_valid,
   output abts_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(NUM_REGS + 1);
   // list bits at or above NUM_REGS never take part
   localparam logic [abts_pkg::LIST_W-1:0] LIST_MASK =
      abts_pkg::LIST_W'((33'd1 << NUM_REGS) - 33'd1);

   // Sequencer:
   //   START  adder forms the first transfer address
   //   END    adder forms the write-back (end) address
   //   CHECK  address space check, memory fault, load write-back item
   //   XFER   one listed register per cycle, adder steps the address by 4
   //   POST   store write-back item
   //   DONE   closing item
   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_END,
      S_CHECK,
      S_XFER,
      S_POST,
      S_DONE
   } state_type;

   state_type                      state_ff;
   logic                           store_ff;
   abts_pkg::mode_type             mode_ff;
   logic                           s_ff;
   logic                           do_wb_ff;
   logic [abts_pkg::REG_W-1:0]     base_reg_ff;
   logic [abts_pkg::ADDR_W-1:0]    base_ff;
   logic                           fault_ff;
   logic                           has_pc_ff;
   logic [abts_pkg::LIST_W-1:0]    rem_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [abts_pkg::ADDR_W-1:0]    addr_ff;
   logic [abts_pkg::ADDR_W-1:0]    end_ff;
   logic                           rsp_valid_ff;
   abts_pkg::rsp_type              rsp_ff;

   logic [abts_pkg::LIST_W-1:0]    list_in;
   logic [CNT_W-1:0]               count_in;
   logic [abts_pkg::ADDR_W-1:0]    size;
   abts_pkg::add_op_type           add_op;
   logic [abts_pkg::ADDR_W-1:0]    add_y;
   logic [abts_pkg::REG_W-1:0]     low_idx;
   logic [abts_pkg::LIST_W-1:0]    rem_in;
   logic                           xfer_ub;
   logic                           wb_ub;
   logic [abts_pkg::CYCLES_W-1:0]  done_cycles;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // register count of the masked list, taken at accept
   always_comb begin
      list_in  = req_data.reg_list & LIST_MASK;
      count_in = '0;
      for (int i = 0; i < abts_pkg::LIST_W; i++) begin
         count_in = count_in + CNT_W'(list_in[i]);
      end
   end

   assign size = abts_pkg::ADDR_W'(count_ff) << 2;

   // operand select for the shared adder
   always_comb begin
      add_op.a   = base_ff;
      add_op.b   = '0;
      add_op.sub = 1'b0;
      unique case (state_ff)
         S_START: begin
            unique case (mode_ff)
               abts_pkg::MODE_IA: begin
                  add_op.b = '0;
               end
               abts_pkg::MODE_IB: begin
                  add_op.b = abts_pkg::ADDR_W'(4);
               end
               abts_pkg::MODE_DB: begin
                  add_op.b   = size;
                  add_op.sub = 1'b1;
               end
               abts_pkg::MODE_DA: begin
                  // base - size + 4
                  add_op.b   = size - abts_pkg::ADDR_W'(4);
                  add_op.sub = 1'b1;
               end
            endcase
         end
         S_END: begin
            add_op.b   = size;
            add_op.sub = ~mode_ff[0];
         end
         S_XFER: begin
            add_op.a = addr_ff;
            add_op.b = abts_pkg::ADDR_W'(4);
         end
         default: begin
            add_op.a = base_ff;
         end
      endcase
   end

   abts_addr_unit u_addr (
      .op (add_op),
      .y  (add_y)
   );

   // lowest register still to move
   always_comb begin
      low_idx = '0;
      for (int i = abts_pkg::LIST_W - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            low_idx = abts_pkg::REG_W'(i);
         end
      end
      rem_in = rem_ff & ~(abts_pkg::LIST_W'(1) << low_idx);
   end

   // bank choice: loads with S and no PC go to the user bank, stores with S too
   assign xfer_ub     = store_ff ? s_ff : (s_ff & ~has_pc_ff);
   assign wb_ub       = ~store_ff & s_ff & ~has_pc_ff;
   assign done_cycles = (count_ff == '0) ? abts_pkg::CYCLES_W'(2)
                                         : abts_pkg::CYCLES_W'(count_ff) + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  store_ff    <= req_data.op;
                  mode_ff     <= req_data.addr_mode;
                  s_ff        <= req_data.s_flag;
                  do_wb_ff    <= req_data.write_back &&
                                 (req_data.base_reg != abts_pkg::PC_REG);
                  base_reg_ff <= req_data.base_reg;
                  base_ff     <= req_data.base_addr;
                  fault_ff    <= req_data.mem_fault;
                  has_pc_ff   <= list_in[abts_pkg::PC_REG];
                  rem_ff      <= list_in;
                  count_ff    <= count_in;
                  state_ff    <= S_START;
               end
            end
            S_START: begin
               addr_ff  <= add_y;
               state_ff <= S_END;
            end
            S_END: begin
               end_ff   <= add_y;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               // address check wins over the memory fault
               if ((addr_ff >> ADDR_SPACE_BITS) != '0) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_ff.kind      <= abts_pkg::KIND_ADDR_EXC;
                  rsp_ff.word_addr <= addr_ff;
                  rsp_ff.cycles    <= abts_pkg::CYCLES_W'(2);
                  rsp_ff.flush     <= 1'b1;
                  rsp_ff.last      <= 1'b1;
                  state_ff         <= S_IDLE;
               end else if (fault_ff) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_ff.kind      <= abts_pkg::KIND_ABORT;
                  rsp_ff.word_addr <= addr_ff;
                  rsp_ff.cycles    <= abts_pkg::CYCLES_W'(2);
                  rsp_ff.flush     <= 1'b1;
                  rsp_ff.last      <= 1'b1;
                  state_ff         <= S_IDLE;
               end else begin
                  // load write-back goes first so a loaded base overrides it
                  if (!store_ff && do_wb_ff) begin
                     rsp_valid_ff     <= 1'b1;
                     rsp_ff.kind      <= abts_pkg::KIND_WB;
                     rsp_ff.reg_num   <= base_reg_ff;
                     rsp_ff.user_bank <= wb_ub;
                     rsp_ff.wb_value  <= end_ff;
                  end
                  state_ff <= S_XFER;
               end
            end
            S_XFER: begin
               if (rem_ff != '0) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.kind        <= abts_pkg::KIND_XFER;
                  rsp_ff.word_addr   <= addr_ff;
                  rsp_ff.reg_num     <= low_idx;
                  rsp_ff.user_bank   <= xfer_ub;
                  rsp_ff.restore_psr <= ~store_ff & s_ff & has_pc_ff &
                                        (low_idx == abts_pkg::PC_REG);
                  addr_ff            <= add_y;
                  rem_ff             <= rem_in;
               end else begin
                  state_ff <= S_POST;
               end
            end
            S_POST: begin
               if (store_ff && do_wb_ff) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_ff.kind     <= abts_pkg::KIND_WB;
                  rsp_ff.reg_num  <= base_reg_ff;
                  rsp_ff.wb_value <= end_ff;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid_ff  <= 1'b1;
               rsp_ff.kind   <= abts_pkg::KIND_DONE;
               rsp_ff.cycles <= done_cycles;
               rsp_ff.flush  <= ~store_ff & has_pc_ff;
               rsp_ff.last   <= 1'b1;
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
